// ===== design/bed_pkg.sv =====
// ---------------------------------------------------------------------------
// Button and encoder event detector package
// Shared constants, event codes and the lane-to-merge event record.
// ---------------------------------------------------------------------------
package bed_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int LEVEL_BITS  = 5;
  localparam int TICK_W      = 32;
  localparam int ENC_W       = 32;
  localparam int IDX_W       = 3;

  // One slot per button plus the encoder slot, which is always the last.
  localparam int NUM_EV = NUM_BUTTONS + 1;
  localparam int SEL_W  = $clog2(NUM_EV);

  localparam int IN_FIELDS_W  = LEVEL_BITS + TICK_W + ENC_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = IDX_W + ENC_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LONG    = 2'd2,
    KIND_ROTATE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } lane_ev_t;

endpackage

// ===== design/bed_button_lane.sv =====
// ---------------------------------------------------------------------------
// Button lane
// Tracks one button's level, press tick and long-press mark, and finds the
// single event that button gives for the current poll.
// ---------------------------------------------------------------------------
module bed_button_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic                        down,
  input  logic [bed_pkg::TICK_W-1:0]  now_ticks,
  input  logic [bed_pkg::TICK_W-1:0]  long_press_ms,
  output bed_pkg::lane_ev_t           lane_ev
);
  import bed_pkg::*;

  logic              was_pressed_r, was_pressed_nxt;
  logic              long_reported_r, long_reported_nxt;
  logic [TICK_W-1:0] press_start_r, press_start_nxt;
  logic [TICK_W-1:0] held;
  logic              long_hit;

  // Hold time wraps with the tick counter.
  assign held     = now_ticks - press_start_r;
  assign long_hit = (held >= long_press_ms);

  always_comb begin
    lane_ev           = '{valid: 1'b0, kind: KIND_PRESS};
    press_start_nxt   = press_start_r;
    long_reported_nxt = long_reported_r;
    if (down && !was_pressed_r) begin
      lane_ev         = '{valid: 1'b1, kind: KIND_PRESS};
      press_start_nxt = now_ticks;
    end else if (!down && was_pressed_r) begin
      lane_ev = '{valid: 1'b1, kind: KIND_RELEASE};
    end else if (down && !long_reported_r && long_hit) begin
      lane_ev           = '{valid: 1'b1, kind: KIND_LONG};
      long_reported_nxt = 1'b1;
    end
    if (!down) begin
      long_reported_nxt = 1'b0;
    end
    was_pressed_nxt = down;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r   <= 1'b0;
      long_reported_r <= 1'b0;
      press_start_r   <= '0;
    end else if (take) begin
      was_pressed_r   <= was_pressed_nxt;
      long_reported_r <= long_reported_nxt;
      press_start_r   <= press_start_nxt;
    end
  end

endmodule

// ===== design/bed_encoder_lane.sv =====
// ---------------------------------------------------------------------------
// Encoder lane
// Forms the wrapped position change against the count of the last rotate
// event and flags a rotate event when it is nonzero.
// ---------------------------------------------------------------------------
module bed_encoder_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic [bed_pkg::ENC_W-1:0]  encoder_count,
  output bed_pkg::lane_ev_t          lane_ev,
  output logic [bed_pkg::ENC_W-1:0]  rotate_delta
);
  import bed_pkg::*;

  logic [ENC_W-1:0] last_encoder_r;

  assign rotate_delta = encoder_count - last_encoder_r;
  assign lane_ev      = '{valid: (rotate_delta != '0), kind: KIND_ROTATE};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_encoder_r <= '0;
    end else if (take && lane_ev.valid) begin
      last_encoder_r <= encoder_count;
    end
  end

endmodule

// ===== design/bed_event_merge.sv =====
// ---------------------------------------------------------------------------
// Event merge
// Captures the events that all lanes found for one poll and hands them to
// the output register one per cycle while the output is not stalled, lowest slot first.
// ---------------------------------------------------------------------------
module bed_event_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bed_pkg::lane_ev_t           lane_ev [bed_pkg::NUM_EV],
  input  logic [bed_pkg::ENC_W-1:0]   rotate_delta,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bed_pkg::kind_t              out_kind,
  output logic [bed_pkg::IDX_W-1:0]   out_index,
  output logic [bed_pkg::ENC_W-1:0]   out_delta,
  output logic                        out_last
);
  import bed_pkg::*;

  logic [NUM_EV-1:0] pend_r, pend_nxt;
  kind_t             kind_r [NUM_EV];
  logic [ENC_W-1:0]  delta_r;

  logic [NUM_EV-1:0] lowest, rest, cap;
  logic [SEL_W-1:0]  sel;
  logic              pop, take;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [ENC_W-1:0]  out_delta_r;
  logic              out_last_r;

  assign lowest = pend_r & (~pend_r + 1'b1);
  assign rest   = pend_r & ~lowest;
  assign pop    = (pend_r != '0) && (!out_valid_r || out_ready);

  // A new poll may enter once the current one is down to its final event.
  assign in_ready = (pend_r == '0) || (pop && rest == '0);
  assign take     = in_valid && in_ready;

  always_comb begin
    sel = '0;
    for (int i = NUM_EV - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = SEL_W'(i);
      end
    end
    for (int i = 0; i < NUM_EV; i++) begin
      cap[i] = lane_ev[i].valid;
    end
    if (take) begin
      pend_nxt = cap;
    end else if (pop) begin
      pend_nxt = rest;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < NUM_EV; i++) begin
        kind_r[i] <= lane_ev[i].kind;
      end
      delta_r <= rotate_delta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind_r <= kind_r[sel];
      out_last_r <= (rest == '0);
      if (kind_r[sel] == KIND_ROTATE) begin
        out_index_r <= '0;
        out_delta_r <= delta_r;
      end else begin
        out_index_r <= IDX_W'(sel);
        out_delta_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_index = out_index_r;
  assign out_delta = out_delta_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/button_and_encoder_event_detector.sv =====
// ---------------------------------------------------------------------------
// Button and encoder event detector
// Turns each poll of button levels, tick count and encoder count into a
// short burst of press, release, long-press and rotate events.
// ---------------------------------------------------------------------------
// Each accepted poll goes through one button lane per button and an encoder
// lane combinationally; the lanes update their state as it is accepted and
// the merge register then sends the poll's events out one per cycle while
// out_tready allows, buttons in index order and the rotate event last, with
// tlast on the final one. A poll gives at most six events; the next poll is
// taken in the cycle its predecessor's last event moves out. After acceptance
// the events wait in the pending register and then pass through the output
// register. A poll that gives no events gives no output at all. The
// long-press threshold resets to 1000 ticks and is written through cfg_,
// which is always ready; write it only while the block is idle.
// ---------------------------------------------------------------------------
module button_and_encoder_event_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bed_pkg::TICK_W-1:0]       cfg_data,      // long_press_ms
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // button_levels[4:0], now_ticks[36:5], encoder_count[68:37], zero pad
  input  logic [bed_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // button_index[2:0], rotate_delta[34:3], zero pad
  output logic [bed_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                       out_tuser,     // event_kind[1:0]
  output logic                             out_tlast      // last_event
);
  import bed_pkg::*;

  logic [TICK_W-1:0]     long_press_ms_r;
  logic [LEVEL_BITS-1:0] button_levels;
  logic [TICK_W-1:0]     now_ticks;
  logic [ENC_W-1:0]      encoder_count;
  logic [NUM_BUTTONS-1:0] down;
  lane_ev_t              lane_ev [NUM_EV];
  logic [ENC_W-1:0]      rotate_delta;
  logic                  take;
  kind_t                 out_kind;
  logic [IDX_W-1:0]      out_index;
  logic [ENC_W-1:0]      out_delta;

  assign button_levels = in_tdata[LEVEL_BITS-1:0];
  assign now_ticks     = in_tdata[LEVEL_BITS +: TICK_W];
  assign encoder_count = in_tdata[LEVEL_BITS+TICK_W +: ENC_W];
  assign take          = in_tvalid && in_tready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_ms_r <= TICK_W'(1000);
    end else if (cfg_valid) begin
      long_press_ms_r <= cfg_data;
    end
  end

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    // Buttons beyond the level field always read as up.
    if (g < LEVEL_BITS) begin : g_lvl
      assign down[g] = button_levels[g];
    end else begin : g_nolvl
      assign down[g] = 1'b0;
    end

    bed_button_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .take          (take),
      .down          (down[g]),
      .now_ticks     (now_ticks),
      .long_press_ms (long_press_ms_r),
      .lane_ev       (lane_ev[g])
    );
  end

  bed_encoder_lane u_enc (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .encoder_count (encoder_count),
    .lane_ev       (lane_ev[NUM_BUTTONS]),
    .rotate_delta  (rotate_delta)
  );

  bed_event_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .lane_ev      (lane_ev),
    .rotate_delta (rotate_delta),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_kind),
    .out_index    (out_index),
    .out_delta    (out_delta),
    .out_last     (out_tlast)
  );

  assign out_tuser = out_kind;
  assign out_tdata = OUT_TDATA_W'({out_delta, out_index});

endmodule

// ===== design/bed_checker.sv =====
// ---------------------------------------------------------------------------
// Event detector port checker
// Watches the top level's ports for output ordering and field rules.
// ---------------------------------------------------------------------------
module bed_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bed_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tlast
);
  import bed_pkg::*;

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output request changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_rot_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ROTATE |-> out_tdata[IDX_W-1:0] == '0
      && out_tdata[IDX_W +: ENC_W] != '0 && out_tlast)
    else $error("rotate event malformed");

  a_btn_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ROTATE |-> out_tdata[IDX_W +: ENC_W] == '0
      && out_tdata[IDX_W-1:0] < IDX_W'(NUM_BUTTONS))
    else $error("button event malformed");

endmodule

bind button_and_encoder_event_detector bed_checker u_bed_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
